/* rtl/core/dhcp_bootp_option_parser_core_macros.svh */
// ----------------------------------------------------------------------------
// dhcp_bootp_option_parser_core_macros
// assertion macros shared by the parser core
// ----------------------------------------------------------------------------
`ifndef DHCP_BOOTP_OPTION_PARSER_CORE_MACROS_SVH
`define DHCP_BOOTP_OPTION_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define DBOP_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("dbop check failed");

// next-cycle implication
`define DBOP_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("dbop check failed");

`endif

/* rtl/core/dbop_pkg.sv */
// ----------------------------------------------------------------------------
// dbop_pkg
// types, constants and helpers for the bootp / dhcp option parser
// ----------------------------------------------------------------------------
package dbop_pkg;

    localparam int HDR_LAST_OFF  = 27;
    localparam int OPT_FIRST_OFF = 240;

    localparam logic [7:0] END_CODE   = 8'hFF;
    localparam logic [7:0] PAD_CODE   = 8'h00;
    localparam logic [7:0] OP_REQUEST = 8'd1;
    localparam logic [7:0] OP_REPLY   = 8'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        REC_HEADER = 2'd0,
        REC_OPTION = 2'd1,
        REC_TERM   = 2'd2,
        REC_UNTERM = 2'd3
    } t_rec_kind;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_opt_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_of_packet;
    } t_in_item;

    typedef struct packed {
        t_rec_kind   record_kind;
        logic [7:0]  bootp_op;
        logic [7:0]  hardware_type;
        logic [7:0]  hardware_len;
        logic [31:0] transaction_id;
        logic [31:0] client_ip;
        logic [31:0] your_ip;
        logic [31:0] server_ip;
        logic [31:0] gateway_ip;
        logic [7:0]  opt_code;
        logic [7:0]  opt_len;
        logic [31:0] opt_value;
    } t_out_item;

    typedef struct packed {
        t_out_item rec;
        logic      tail_unterm;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic tail_pend;
    } t_back_status;

    // leading value bytes reported for an option code
    function automatic logic [2:0] bytes_taken(input logic [7:0] code);
        logic [2:0] n;
        unique case (code)
            8'd53: n = 3'd1;
            8'd1, 8'd2, 8'd3, 8'd6, 8'd28, 8'd44, 8'd50, 8'd51, 8'd54: n = 3'd4;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/core/dhcp_bootp_option_parser_core.sv */
// ----------------------------------------------------------------------------
// dhcp_bootp_option_parser_core
// bootp / dhcp message parser: header record and option records per message
// ----------------------------------------------------------------------------
//  channel  direction  handshake                        payload
//  in       input      i_in_valid / o_in_stall          i_in_item  (one byte)
//  out      output     o_out_valid / i_out_stall        o_out_item (one record)
//
//  one byte item accepted per cycle while o_in_stall is low; a record goes through the queue, then the output register
//  a byte that closes the message may give two records, sent one after the other
//  o_in_stall rises only when the four-entry record queue is full
//  synchronous active-low reset clears the parse state, queue and output stage
// ----------------------------------------------------------------------------
`include "dhcp_bootp_option_parser_core_macros.svh"

module dhcp_bootp_option_parser_core #(
    parameter int MAX_MESSAGE_BYTES = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  dbop_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output dbop_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import dbop_pkg::*;

    logic         w_push;
    t_q_entry     w_push_entry;
    logic         w_pop;
    t_q_entry     w_head;
    t_q_status    w_q_stat;
    t_back_status w_back_stat;

    dbop_front #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_q_full     (w_q_stat.full),
        .o_push       (w_push),
        .o_push_entry (w_push_entry)
    );

    dbop_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_stat       (w_q_stat)
    );

    dbop_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_stat      (w_back_stat)
    );

    `DBOP_ASSERT_IMP(a_push_room, i_clk, !i_rst_n, w_push, !w_q_stat.full)
    `DBOP_ASSERT_IMP(a_tail_shown, i_clk, !i_rst_n, w_back_stat.tail_pend, o_out_valid && (o_out_item.record_kind == REC_HEADER || o_out_item.record_kind == REC_OPTION))
    `DBOP_ASSERT_NXT(a_tail_next, i_clk, !i_rst_n, w_back_stat.tail_pend && !i_out_stall, o_out_valid && o_out_item.record_kind == REC_UNTERM)

endmodule

/* rtl/core/dbop_front.sv */
// ----------------------------------------------------------------------------
// dbop_front
// byte intake: offset tracking, header capture and option walk
// ----------------------------------------------------------------------------
module dbop_front #(
    parameter int MAX_MESSAGE_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  dbop_pkg::t_in_item i_in_item,
    output logic               o_in_stall,
    input  logic               i_q_full,
    output logic               o_push,
    output dbop_pkg::t_q_entry o_push_entry
);
    import dbop_pkg::*;

    localparam int OFF_W = $clog2(MAX_MESSAGE_BYTES + 1);

    logic [OFF_W-1:0] r_offset, n_offset;
    logic [7:0]       r_op, n_op;
    logic [7:0]       r_htype, n_htype;
    logic [7:0]       r_hlen, n_hlen;
    logic [31:0]      r_xid, n_xid;
    logic [31:0]      r_ciaddr, n_ciaddr;
    logic [31:0]      r_yiaddr, n_yiaddr;
    logic [31:0]      r_siaddr, n_siaddr;
    logic [31:0]      r_giaddr, n_giaddr;
    t_opt_phase       r_phase, n_phase;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_rem, n_rem;
    logic [31:0]      r_acc, n_acc;
    logic             r_done, n_done;

    logic       accept;
    logic       in_range;
    logic       first_fire;
    logic       end_fire;
    t_out_item  first_rec;
    t_out_item  unterm_rec;
    logic [7:0] b;
    logic [7:0] vidx;
    logic [2:0] taken;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign b          = i_in_item.data_byte;
    assign in_range   = r_offset < OFF_W'(MAX_MESSAGE_BYTES);
    assign taken      = bytes_taken(r_code);
    assign vidx       = r_len - r_rem;

    always_comb begin
        n_offset   = r_offset;
        n_op       = r_op;
        n_htype    = r_htype;
        n_hlen     = r_hlen;
        n_xid      = r_xid;
        n_ciaddr   = r_ciaddr;
        n_yiaddr   = r_yiaddr;
        n_siaddr   = r_siaddr;
        n_giaddr   = r_giaddr;
        n_phase    = r_phase;
        n_code     = r_code;
        n_len      = r_len;
        n_rem      = r_rem;
        n_acc      = r_acc;
        n_done     = r_done;
        first_fire = 1'b0;
        end_fire   = 1'b0;
        first_rec  = '0;

        if (accept) begin
            if (in_range) begin
                priority if (r_offset == OFF_W'(0)) begin
                    n_op = b;
                end else if (r_offset == OFF_W'(1)) begin
                    n_htype = b;
                end else if (r_offset == OFF_W'(2)) begin
                    n_hlen = b;
                end else if (r_offset >= OFF_W'(4) && r_offset <= OFF_W'(7)) begin
                    n_xid = {r_xid[23:0], b};
                end else if (r_offset >= OFF_W'(12) && r_offset <= OFF_W'(15)) begin
                    n_ciaddr = {r_ciaddr[23:0], b};
                end else if (r_offset >= OFF_W'(16) && r_offset <= OFF_W'(19)) begin
                    n_yiaddr = {r_yiaddr[23:0], b};
                end else if (r_offset >= OFF_W'(20) && r_offset <= OFF_W'(23)) begin
                    n_siaddr = {r_siaddr[23:0], b};
                end else if (r_offset >= OFF_W'(24) && r_offset <= OFF_W'(27)) begin
                    n_giaddr = {r_giaddr[23:0], b};
                end else begin
                end

                if (r_offset == OFF_W'(HDR_LAST_OFF)) begin
                    first_fire               = 1'b1;
                    first_rec.record_kind    = REC_HEADER;
                    first_rec.bootp_op       = r_op;
                    first_rec.hardware_type  = r_htype;
                    first_rec.hardware_len   = r_hlen;
                    first_rec.transaction_id = r_xid;
                    first_rec.client_ip      = (r_op == OP_REQUEST) ? r_ciaddr : 32'd0;
                    first_rec.your_ip        = r_yiaddr;
                    first_rec.server_ip      = (r_op == OP_REPLY) ? r_siaddr : 32'd0;
                    first_rec.gateway_ip     = n_giaddr;
                end

                if (r_offset >= OFF_W'(OPT_FIRST_OFF) && !r_done) begin
                    unique case (r_phase)
                        PH_CODE: begin
                            if (b == END_CODE || b == PAD_CODE) begin
                                first_fire            = 1'b1;
                                first_rec.record_kind = REC_TERM;
                                first_rec.opt_code    = b;
                                n_done                = 1'b1;
                            end else begin
                                n_code  = b;
                                n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            n_len = b;
                            n_rem = b;
                            n_acc = 32'd0;
                            if (b == 8'd0) begin
                                first_fire            = 1'b1;
                                first_rec.record_kind = REC_OPTION;
                                first_rec.opt_code    = r_code;
                                n_phase               = PH_CODE;
                            end else begin
                                n_phase = PH_VALUE;
                            end
                        end
                        PH_VALUE: begin
                            if (vidx < {5'd0, taken}) begin
                                n_acc = {r_acc[23:0], b};
                            end
                            n_rem = r_rem - 8'd1;
                            if (n_rem == 8'd0) begin
                                first_fire            = 1'b1;
                                first_rec.record_kind = REC_OPTION;
                                first_rec.opt_code    = r_code;
                                first_rec.opt_len     = r_len;
                                first_rec.opt_value   = (taken != 3'd0) ? n_acc : 32'd0;
                                n_phase               = PH_CODE;
                            end
                        end
                        default: begin
                            n_phase = PH_CODE;
                        end
                    endcase
                end

                n_offset = r_offset + OFF_W'(1);
            end

            if (i_in_item.last_of_packet) begin
                end_fire = !n_done;
                n_offset = '0;
                n_op     = '0;
                n_htype  = '0;
                n_hlen   = '0;
                n_xid    = '0;
                n_ciaddr = '0;
                n_yiaddr = '0;
                n_siaddr = '0;
                n_giaddr = '0;
                n_phase  = PH_CODE;
                n_code   = '0;
                n_len    = '0;
                n_rem    = '0;
                n_acc    = '0;
                n_done   = 1'b0;
            end
        end
    end

    always_comb begin
        unterm_rec             = '0;
        unterm_rec.record_kind = REC_UNTERM;
    end

    assign o_push                   = first_fire || end_fire;
    assign o_push_entry.rec         = first_fire ? first_rec : unterm_rec;
    assign o_push_entry.tail_unterm = first_fire && end_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_op     <= '0;
            r_htype  <= '0;
            r_hlen   <= '0;
            r_xid    <= '0;
            r_ciaddr <= '0;
            r_yiaddr <= '0;
            r_siaddr <= '0;
            r_giaddr <= '0;
            r_phase  <= PH_CODE;
            r_code   <= '0;
            r_len    <= '0;
            r_rem    <= '0;
            r_acc    <= '0;
            r_done   <= 1'b0;
        end else begin
            r_offset <= n_offset;
            r_op     <= n_op;
            r_htype  <= n_htype;
            r_hlen   <= n_hlen;
            r_xid    <= n_xid;
            r_ciaddr <= n_ciaddr;
            r_yiaddr <= n_yiaddr;
            r_siaddr <= n_siaddr;
            r_giaddr <= n_giaddr;
            r_phase  <= n_phase;
            r_code   <= n_code;
            r_len    <= n_len;
            r_rem    <= n_rem;
            r_acc    <= n_acc;
            r_done   <= n_done;
        end
    end

endmodule

/* rtl/core/dbop_queue.sv */
// ----------------------------------------------------------------------------
// dbop_queue
// small record queue between intake and output
// ----------------------------------------------------------------------------
module dbop_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  dbop_pkg::t_q_entry   i_push_entry,
    input  logic                 i_pop,
    output dbop_pkg::t_q_entry   o_head,
    output dbop_pkg::t_q_status  o_stat
);
    import dbop_pkg::*;

    t_q_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]     r_count, n_count;
    logic                  push_ok;
    logic                  pop_ok;

    assign o_stat.full  = r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push_ok ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = pop_ok ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        unique case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + (QUEUE_AW + 1)'(1);
            2'b01:   n_count = r_count - (QUEUE_AW + 1)'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

/* rtl/core/dbop_back.sv */
// ----------------------------------------------------------------------------
// dbop_back
// record output stage: unpacks queue entries into result items
// ----------------------------------------------------------------------------
module dbop_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dbop_pkg::t_q_entry     i_head,
    input  dbop_pkg::t_q_status    i_q_stat,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output dbop_pkg::t_out_item    o_out_item,
    input  logic                   i_out_stall,
    output dbop_pkg::t_back_status o_stat
);
    import dbop_pkg::*;

    logic      r_out_valid, n_out_valid;
    logic      r_tail, n_tail;
    t_out_item r_out_item, n_out_item;
    logic      take;
    logic      load_ok;

    assign take    = r_out_valid && !i_out_stall;
    assign load_ok = !r_out_valid || take;
    assign o_pop   = load_ok && !r_tail && !i_q_stat.empty;

    always_comb begin
        n_out_valid = r_out_valid;
        n_tail      = r_tail;
        n_out_item  = r_out_item;
        if (load_ok) begin
            priority if (r_tail) begin
                n_out_item             = '0;
                n_out_item.record_kind = REC_UNTERM;
                n_tail                 = 1'b0;
                n_out_valid            = 1'b1;
            end else if (!i_q_stat.empty) begin
                n_out_item  = i_head.rec;
                n_tail      = i_head.tail_unterm;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_tail      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out_item;
    assign o_stat.tail_pend = r_tail;

endmodule
